// ===== rtl/swdq_pkg.sv =====
// Package for the debounced key event queue.
// Holds switch codes, command and register indexes, ring sizing and shared helpers.
// No dependencies.
package swdq_pkg;

   localparam int RING_DEPTH = 8;
   localparam int RING_AW    = $clog2(RING_DEPTH);
   localparam int NUM_KEYS   = 3;
   localparam int TIME_W     = 32;
   localparam int DEB_W      = 16;
   localparam int KEY_W      = 2;

   // stable sample count saturates at three; two repeats make a state stable
   localparam logic [1:0] STABLE_MAX = 2'd3;
   localparam logic [1:0] STABLE_MIN = 2'd2;

   typedef enum logic [2:0] {
      SW_NONE    = 3'd0,
      SW_PLUS    = 3'd1,
      SW_MINUS   = 3'd2,
      SW_CENTER  = 3'd3,
      SW_INVALID = 3'd4
   } sw_code_type;

   typedef enum logic {
      CMD_POLL    = 1'b0,
      CMD_CAPTURE = 1'b1
   } cmd_type;

   typedef enum logic {
      CSR_DEBOUNCE    = 1'b0,
      CSR_MOTION_HOLD = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic             nonempty;
      logic [KEY_W-1:0] key;
   } ring_status_type;

   function automatic sw_code_type classify(input logic p, input logic m, input logic c);
      sw_code_type code;
      case ({c, m, p})
         3'b000:  code = SW_NONE;
         3'b001:  code = SW_PLUS;
         3'b010:  code = SW_MINUS;
         3'b100:  code = SW_CENTER;
         default: code = SW_INVALID;
      endcase
      return code;
   endfunction

   function automatic logic [RING_AW-1:0] ring_next(input logic [RING_AW-1:0] ptr);
      logic [RING_AW-1:0] nxt;
      if (ptr == RING_AW'(RING_DEPTH - 1)) begin
         nxt = '0;
      end else begin
         nxt = ptr + RING_AW'(1);
      end
      return nxt;
   endfunction

endpackage

// ===== rtl/switch_debounce_event_queue_unit.sv =====
// Debounced key event queue, top level.
// Latency: the result of an item is valid in the cycle after it is accepted.
// Throughput: one item per cycle unless stalled; output register refills as it is taken.
// Reset: synchronous, clears all key, timer and ring pointer state and loads
// debounce 50 ms and motion hold 30000 ms; ring entries are not cleared.
// Depends on swdq_pkg, swdq_ring and swdq_poll.
module switch_debounce_event_queue_unit import swdq_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // now_ms, plus_pressed, minus_pressed, center_pressed,
                                    // body_present, zero fill
   input  logic        req_tuser,   // command
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // key_event, motion_active, zero fill
   input  logic        csr_we,
   input  logic        csr_addr,
   input  logic [31:0] csr_wdata
);

   logic [DEB_W-1:0]  debounce_ff;
   logic [TIME_W-1:0] hold_ff;
   logic              rsp_valid_ff;
   logic [KEY_W-1:0]  key_ff;
   logic              motion_ff;
   logic              accept;
   logic              capture_go;
   logic              poll_go;
   logic [TIME_W-1:0] now_ms;
   logic [NUM_KEYS-1:0] pressed;
   sw_code_type       sw;
   ring_status_type   status;
   logic [KEY_W-1:0]  key_event;
   logic              motion_active;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign capture_go = accept && (cmd_type'(req_tuser) == CMD_CAPTURE);
   assign poll_go    = accept && (cmd_type'(req_tuser) == CMD_POLL);
   assign now_ms     = req_tdata[TIME_W-1:0];
   assign pressed    = req_tdata[TIME_W+NUM_KEYS-1:TIME_W];
   assign sw         = classify(pressed[0], pressed[1], pressed[2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff <= DEB_W'(50);
         hold_ff     <= TIME_W'(30000);
      end else if (csr_we) begin
         case (csr_index_type'(csr_addr))
            CSR_DEBOUNCE:    debounce_ff <= csr_wdata[DEB_W-1:0];
            CSR_MOTION_HOLD: hold_ff     <= csr_wdata;
            default:         ;
         endcase
      end
   end

   swdq_ring u_ring (
      .clock       (clock),
      .reset       (reset),
      .capture_go  (capture_go),
      .poll_go     (poll_go),
      .now_ms      (now_ms),
      .pressed     (pressed),
      .debounce_ms (debounce_ff),
      .status      (status)
   );

   swdq_poll u_poll (
      .clock          (clock),
      .reset          (reset),
      .poll_go        (poll_go),
      .now_ms         (now_ms),
      .sw             (sw),
      .body_present   (req_tdata[TIME_W+NUM_KEYS]),
      .debounce_ms    (debounce_ff),
      .motion_hold_ms (hold_ff),
      .status         (status),
      .key_event      (key_event),
      .motion_active  (motion_active)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_tready) begin
         rsp_valid_ff <= req_tvalid;
      end
   end

   // hold the result until it is taken
   always_ff @(posedge clock) begin
      if (accept) begin
         key_ff    <= key_event;
         motion_ff <= motion_active;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b0, motion_ff, key_ff};

endmodule

// ===== rtl/swdq_ring.sv =====
// Event ring for the debounced key event queue: key latches, per-key rate limit,
// ring storage with head and tail. Depends on swdq_pkg.
module swdq_ring import swdq_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                capture_go,
   input  logic                poll_go,
   input  logic [TIME_W-1:0]   now_ms,
   input  logic [NUM_KEYS-1:0] pressed,
   input  logic [DEB_W-1:0]    debounce_ms,
   output ring_status_type     status
);

   logic [KEY_W-1:0]    ring_ff [RING_DEPTH];
   logic [RING_AW-1:0]  head_ff, head_in;
   logic [RING_AW-1:0]  tail_ff, tail_in;
   logic [NUM_KEYS-1:0] latch_ff, latch_in;
   logic [TIME_W-1:0]   qtime_ff [NUM_KEYS];
   logic [TIME_W-1:0]   qtime_in [NUM_KEYS];
   logic [NUM_KEYS-1:0] push;
   logic [RING_AW-1:0]  slot [NUM_KEYS];

   assign status.nonempty = (head_ff != tail_ff);
   assign status.key      = ring_ff[tail_ff];

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      latch_in = latch_ff;
      qtime_in = qtime_ff;
      push     = '0;
      // keys go in order plus, minus, centre; each sees the head left by the previous
      for (int k = 0; k < NUM_KEYS; k++) begin
         slot[k] = head_in;
         if (capture_go && pressed[k] && !latch_ff[k] &&
             ((now_ms - qtime_ff[k]) >= {{(TIME_W-DEB_W){1'b0}}, debounce_ms}) &&
             (ring_next(head_in) != tail_ff)) begin
            push[k]     = 1'b1;
            head_in     = ring_next(head_in);
            qtime_in[k] = now_ms;
         end
      end
      if (capture_go) begin
         latch_in = pressed;
      end
      if (poll_go && status.nonempty) begin
         tail_in = ring_next(tail_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         latch_ff <= '0;
         for (int k = 0; k < NUM_KEYS; k++) begin
            qtime_ff[k] <= '0;
         end
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         latch_ff <= latch_in;
         qtime_ff <= qtime_in;
      end
   end

   // ring storage has no reset; only written entries are ever popped
   always_ff @(posedge clock) begin
      for (int k = 0; k < NUM_KEYS; k++) begin
         if (push[k]) begin
            ring_ff[slot[k]] <= KEY_W'(k + 1);
         end
      end
   end

endmodule

// ===== rtl/swdq_poll.sv =====
// Poll path of the debounced key event queue: motion hold, switch sampler with
// stable count, and press suppression after a queued event. Depends on swdq_pkg.
module swdq_poll import swdq_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              poll_go,
   input  logic [TIME_W-1:0] now_ms,
   input  sw_code_type       sw,
   input  logic              body_present,
   input  logic [DEB_W-1:0]  debounce_ms,
   input  logic [TIME_W-1:0] motion_hold_ms,
   input  ring_status_type   status,
   output logic [KEY_W-1:0]  key_event,
   output logic              motion_active
);

   logic [TIME_W-1:0] deadline_ff, deadline_in;
   logic              flag_ff, flag_in;
   logic [TIME_W-1:0] sample_ff, sample_in;
   sw_code_type       raw_ff, raw_in;
   sw_code_type       stable_ff, stable_in;
   logic [1:0]        count_ff, count_in;
   logic              suppress_ff, suppress_in;
   logic [TIME_W-1:0] diff;
   sw_code_type       ev;

   always_comb begin
      deadline_in = deadline_ff;
      flag_in     = flag_ff;
      sample_in   = sample_ff;
      raw_in      = raw_ff;
      stable_in   = stable_ff;
      count_in    = count_ff;
      suppress_in = suppress_ff;
      ev          = SW_NONE;
      // with body high the new deadline minus now is the hold time itself
      diff        = body_present ? motion_hold_ms : (deadline_ff - now_ms);
      if (poll_go) begin
         if (body_present) begin
            deadline_in = now_ms + motion_hold_ms;
         end
         flag_in = (diff != '0) && !diff[TIME_W-1];
         if (status.nonempty) begin
            ev          = sw_code_type'({1'b0, status.key});
            suppress_in = 1'b1;
         end else if ((now_ms - sample_ff) >= {{(TIME_W-DEB_W){1'b0}}, debounce_ms}) begin
            sample_in = now_ms;
            if (sw == raw_ff) begin
               if (count_ff < STABLE_MAX) begin
                  count_in = count_ff + 2'd1;
               end
            end else begin
               raw_in   = sw;
               count_in = '0;
            end
            if (count_in >= STABLE_MIN && sw != stable_ff) begin
               stable_in = sw;
               if (stable_ff == SW_NONE && sw != SW_NONE && sw != SW_INVALID) begin
                  if (suppress_ff) begin
                     suppress_in = 1'b0;
                  end else begin
                     ev = sw;
                  end
               end
            end
         end
      end
   end

   assign key_event     = ev[KEY_W-1:0];
   assign motion_active = flag_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         deadline_ff <= '0;
         flag_ff     <= 1'b0;
         sample_ff   <= '0;
         raw_ff      <= SW_NONE;
         stable_ff   <= SW_NONE;
         count_ff    <= '0;
         suppress_ff <= 1'b0;
      end else begin
         deadline_ff <= deadline_in;
         flag_ff     <= flag_in;
         sample_ff   <= sample_in;
         raw_ff      <= raw_in;
         stable_ff   <= stable_in;
         count_ff    <= count_in;
         suppress_ff <= suppress_in;
      end
   end

endmodule

// ===== rtl/swdq_checker.sv =====
// Port-level checks for the debounced key event queue.
// Bound to switch_debounce_event_queue_unit; depends on swdq_pkg.
module swdq_checker import swdq_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [39:0] req_tdata,
   input logic        req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [7:0]  rsp_tdata,
   input logic        csr_we,
   input logic        csr_addr,
   input logic [31:0] csr_wdata
);

   // every accepted item shows its result in the next cycle
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> rsp_tvalid)
      else $error("accepted item gave no result");

   // a capture never reports a key
   a_capture_no_key: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (cmd_type'(req_tuser) == CMD_CAPTURE)
      |=> rsp_tdata[1:0] == 2'd0)
      else $error("capture reported a key event");

   // a waiting result blocks the input side
   a_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("item accepted while result stalled");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

endmodule

bind switch_debounce_event_queue_unit swdq_checker u_swdq_checker (.*);

// ===== tb/swdq_checker.sv =====
// Checker for the debounced key event queue: watches the item, result and register ports,
// predicts each result from its own copy of the key, timer and ring state, and counts mismatches.
// Depends on swdq_pkg.
`timescale 1ns / 1ps

module swdq_tb_checker import swdq_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [39:0] req_tdata,   // now_ms, plus_pressed, minus_pressed, center_pressed,
                                    // body_present, zero fill
   input  logic        req_tuser,   // command
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [7:0]  rsp_tdata,   // key_event, motion_active, zero fill
   input  logic        csr_we,
   input  logic        csr_addr,
   input  logic [31:0] csr_wdata,
   output int          failures,
   output int          outstanding
);

   localparam logic [15:0] DEBOUNCE_AT_RESET = 16'd50;
   localparam logic [31:0] HOLD_AT_RESET     = 32'd30000;

   typedef struct packed {
      logic [1:0] key_event;
      logic       motion_active;
   } key_report_type;

   key_report_type expected_reports[$];
   int          mismatch_count;

   logic [15:0]     debounce_q;
   logic [31:0]     hold_q;
   logic [31:0]     motion_deadline_q;
   logic            motion_q;
   logic [31:0]     last_sample_q;
   sw_code_type     raw_q;
   sw_code_type     stable_q;
   logic [1:0]      stable_cnt;
   logic            suppress_q;
   logic [2:0]      latch_q;
   logic [31:0]     queued_at[NUM_KEYS];
   logic [KEY_W-1:0] ring_q[RING_DEPTH];
   int              ring_head;
   int              ring_tail;

   function automatic sw_code_type switch_state(input logic [2:0] keys);
      sw_code_type code;
      if (keys == 3'b000) begin
         code = SW_NONE;
      end else if ($countones(keys) > 1) begin
         code = SW_INVALID;
      end else if (keys[0]) begin
         code = SW_PLUS;
      end else if (keys[1]) begin
         code = SW_MINUS;
      end else begin
         code = SW_CENTER;
      end
      return code;
   endfunction

   // drop the event when its key is still inside the debounce window or the ring is full
   task automatic queue_key_event(input int k, input logic [31:0] now);
      logic [31:0] elapsed;
      int          nxt;
      elapsed = now - queued_at[k];
      if (elapsed < {16'b0, debounce_q}) return;
      nxt = (ring_head + 1) % RING_DEPTH;
      if (nxt == ring_tail) return;
      ring_q[ring_head] = KEY_W'(k + 1);
      ring_head = nxt;
      queued_at[k] = now;
   endtask

   task automatic predict_report(input logic capture, input logic [31:0] now,
                                 input logic [2:0] keys, input logic body,
                                 output key_report_type rpt);
      logic [31:0] remaining;
      logic [31:0] elapsed;
      sw_code_type sw;
      sw_code_type prior;
      rpt.key_event = '0;
      if (capture) begin
         for (int k = 0; k < NUM_KEYS; k++) begin
            if (keys[k] && !latch_q[k]) queue_key_event(k, now);
         end
         latch_q = keys;
      end else begin
         if (body) motion_deadline_q = now + hold_q;
         remaining = motion_deadline_q - now;
         motion_q = (remaining != 32'd0) && !remaining[31];
         elapsed = now - last_sample_q;
         if (ring_tail != ring_head) begin
            rpt.key_event = ring_q[ring_tail];
            ring_tail = (ring_tail + 1) % RING_DEPTH;
            suppress_q = 1'b1;
         end else if (elapsed >= {16'b0, debounce_q}) begin
            last_sample_q = now;
            sw = switch_state(keys);
            if (sw == raw_q) begin
               if (stable_cnt < STABLE_MAX) stable_cnt++;
            end else begin
               raw_q = sw;
               stable_cnt = '0;
            end
            if (stable_cnt >= STABLE_MIN && sw != stable_q) begin
               prior = stable_q;
               stable_q = sw;
               // only a clean press out of the released state reports a key
               if (prior == SW_NONE && sw != SW_NONE && sw != SW_INVALID) begin
                  if (suppress_q) begin
                     suppress_q = 1'b0;
                  end else begin
                     rpt.key_event = 2'(sw);
                  end
               end
            end
         end
      end
      rpt.motion_active = motion_q;
   endtask

   always @(posedge clock) begin
      key_report_type seen;
      key_report_type want;
      if (reset) begin
         debounce_q = DEBOUNCE_AT_RESET;
         hold_q = HOLD_AT_RESET;
         motion_deadline_q = '0;
         motion_q = 1'b0;
         last_sample_q = '0;
         raw_q = SW_NONE;
         stable_q = SW_NONE;
         stable_cnt = '0;
         suppress_q = 1'b0;
         latch_q = '0;
         for (int k = 0; k < NUM_KEYS; k++) queued_at[k] = '0;
         ring_head = 0;
         ring_tail = 0;
         expected_reports.delete();
         mismatch_count = 0;
      end else begin
         if (csr_we) begin
            if (csr_addr == CSR_DEBOUNCE) begin
               debounce_q = csr_wdata[15:0];
            end else begin
               hold_q = csr_wdata;
            end
         end
         // compare before predicting: a result in this cycle belongs to an older item
         if (rsp_tvalid && rsp_tready) begin
            seen.key_event = rsp_tdata[1:0];
            seen.motion_active = rsp_tdata[2];
            if (expected_reports.size() == 0) begin
               $display("%0t: unexpected key report, key_event %0d motion_active %0d",
                        $time, seen.key_event, seen.motion_active);
               mismatch_count++;
            end else begin
               want = expected_reports.pop_front();
               if (seen.key_event != want.key_event
                   || seen.motion_active != want.motion_active) begin
                  $display("%0t: key report mismatch, expected key_event %0d %s %0d,",
                           $time, want.key_event, "motion_active", want.motion_active,
                           " got key_event %0d motion_active %0d",
                           seen.key_event, seen.motion_active);
                  mismatch_count++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            predict_report(req_tuser == CMD_CAPTURE, req_tdata[31:0], req_tdata[34:32],
                           req_tdata[35], want);
            expected_reports.push_back(want);
         end
      end
      failures <= mismatch_count;
      outstanding <= expected_reports.size();
   end

endmodule

// ===== tb/switch_debounce_event_queue_unit_test.sv =====
// Testbench top for the debounced key event queue: drives directed and random key
// gestures, captures and polls under several register settings, and gives the verdict.
// Depends on swdq_pkg, swdq_tb_checker and the block under test.
`timescale 1ns / 1ps

module switch_debounce_event_queue_unit_test;
   import swdq_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int HOLD_OFF_CYCLES = 300;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [39:0] req_tdata;   // now_ms, plus_pressed, minus_pressed, center_pressed,
                             // body_present, zero fill
   logic        req_tuser;   // command
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [7:0]  rsp_tdata;   // key_event, motion_active, zero fill
   logic        csr_we;
   logic        csr_addr;
   logic [31:0] csr_wdata;

   int          failures;
   int          outstanding;

   logic [31:0] now_q;
   logic [15:0] debounce_setting;
   int          items_sent;
   int          burst_left;
   logic        offering;
   logic        steady_send;
   logic        hold_request;
   int          rx_mode;
   int          rx_left;
   int          cycle_count = 0;

   always #5 clock = ~clock;

   switch_debounce_event_queue_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   swdq_tb_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_we      (csr_we),
      .csr_addr    (csr_addr),
      .csr_wdata   (csr_wdata),
      .failures    (failures),
      .outstanding (outstanding)
   );

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAIL switch_debounce_event_queue_unit");
         $finish;
      end
   end

   // receiver: random stall patterns, plus one long hold-off on request
   initial begin
      rsp_tready <= 1'b0;
      rx_left = 0;
      rx_mode = 0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end else begin
            if (rx_left == 0) begin
               rx_mode = $urandom_range(0, 3);
               rx_left = $urandom_range(10, 80);
            end
            rx_left--;
            case (rx_mode)
               0: rsp_tready <= 1'b1;
               1: rsp_tready <= 1'($urandom_range(0, 1));
               2: rsp_tready <= ($urandom_range(0, 3) == 0);
               default: rsp_tready <= ($urandom_range(0, 4) != 0);
            endcase
         end
      end
   end

   task automatic send(input cmd_type cmd, input logic [2:0] keys, input logic body);
      int gap;
      req_tvalid <= 1'b1;
      req_tuser <= cmd;
      req_tdata <= {4'b0000, body, keys, now_q};
      offering = 1'b1;
      do @(posedge clock); while (!req_tready);
      items_sent++;
      if (!steady_send) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = $urandom_range(1, 9);
            req_tvalid <= 1'b0;
            offering = 1'b0;
            repeat (gap) @(posedge clock);
         end else begin
            burst_left--;
         end
      end
   endtask

   task automatic send_at(input logic [31:0] t, input cmd_type cmd, input logic [2:0] keys,
                          input logic body);
      now_q = t;
      send(cmd, keys, body);
   endtask

   // mostly one debounce interval or a bit more, so that polls sample
   task automatic advance_clock();
      logic [31:0] deb;
      int          pick;
      deb = {16'b0, debounce_setting};
      pick = $urandom_range(0, 19);
      if (pick < 13) begin
         now_q = now_q + deb + $urandom_range(0, debounce_setting / 2 + 2);
      end else if (pick < 17) begin
         now_q = now_q + $urandom_range(0, deb);
      end else if (pick < 19) begin
         now_q = now_q + $urandom();
      end
   endtask

   function automatic logic body_level();
      return $urandom_range(0, 3) == 0;
   endfunction

   // press, hold through several polls, release, and poll the released keys again
   task automatic key_gesture();
      logic [2:0] keys;
      int         pick;
      pick = $urandom_range(0, 19);
      if (pick < 15) begin
         keys = 3'b001 << $urandom_range(0, 2);
      end else if (pick < 18) begin
         keys = 3'($urandom_range(3, 7));
      end else begin
         keys = 3'b000;
      end
      advance_clock();
      send(CMD_CAPTURE, keys, body_level());
      repeat ($urandom_range(2, 6)) begin
         advance_clock();
         // inject a bounce now and then
         send(CMD_POLL, ($urandom_range(0, 9) == 0) ? 3'($urandom_range(0, 7)) : keys,
              body_level());
      end
      advance_clock();
      send(CMD_CAPTURE, 3'b000, body_level());
      repeat ($urandom_range(2, 5)) begin
         advance_clock();
         send(CMD_POLL, 3'b000, body_level());
      end
   endtask

   // press and release keys quickly with no polls, so the ring fills and drops
   task automatic press_flurry();
      logic [2:0] keys;
      repeat ($urandom_range(6, 12)) begin
         keys = 3'b001 << $urandom_range(0, 2);
         advance_clock();
         send(CMD_CAPTURE, keys, body_level());
         send(CMD_CAPTURE, 3'b000, body_level());
      end
   endtask

   task automatic noise_item();
      advance_clock();
      send(cmd_type'($urandom_range(0, 1)), 3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
   endtask

   task automatic random_items(input int n);
      int target;
      int pick;
      target = items_sent + n;
      while (items_sent < target) begin
         pick = $urandom_range(0, 9);
         if (pick < 6) begin
            key_gesture();
         end else if (pick < 8) begin
            press_flurry();
         end else begin
            repeat ($urandom_range(1, 4)) noise_item();
         end
      end
   endtask

   task automatic drain();
      if (offering) begin
         req_tvalid <= 1'b0;
         offering = 1'b0;
      end
      do @(posedge clock); while (outstanding != 0);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_regs(input logic [15:0] deb, input logic [31:0] hold);
      csr_we <= 1'b1;
      csr_addr <= CSR_DEBOUNCE;
      csr_wdata <= {16'b0, deb};
      @(posedge clock);
      csr_addr <= CSR_MOTION_HOLD;
      csr_wdata <= hold;
      @(posedge clock);
      csr_we <= 1'b0;
      debounce_setting = deb;
   endtask

   task automatic run_phase(input logic [15:0] deb, input logic [31:0] hold, input int n);
      drain();
      write_regs(deb, hold);
      random_items(n);
   endtask

   initial begin
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      req_tuser <= CMD_POLL;
      csr_we <= 1'b0;
      csr_addr <= CSR_DEBOUNCE;
      csr_wdata <= '0;
      items_sent = 0;
      burst_left = 0;
      offering = 1'b0;
      steady_send = 1'b0;
      hold_request = 1'b0;
      debounce_setting = 16'd50;
      now_q = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed: captures of all keys, dequeue with suppression, stable press,
      // invalid multi-key state, motion across the time wrap
      send_at(32'd0, CMD_POLL, 3'b000, 1'b0);
      send_at(32'd100, CMD_CAPTURE, 3'b001, 1'b0);
      send_at(32'd101, CMD_CAPTURE, 3'b111, 1'b1);
      send_at(32'd102, CMD_CAPTURE, 3'b000, 1'b0);
      send_at(32'd103, CMD_POLL, 3'b000, 1'b1);
      send_at(32'd104, CMD_POLL, 3'b000, 1'b0);
      send_at(32'd105, CMD_POLL, 3'b000, 1'b0);
      send_at(32'd106, CMD_POLL, 3'b000, 1'b0);
      send_at(32'd200, CMD_POLL, 3'b000, 1'b0);
      send_at(32'd300, CMD_POLL, 3'b000, 1'b0);
      send_at(32'd400, CMD_POLL, 3'b001, 1'b0);
      send_at(32'd500, CMD_POLL, 3'b001, 1'b0);
      send_at(32'd600, CMD_POLL, 3'b001, 1'b0);
      send_at(32'd700, CMD_POLL, 3'b000, 1'b0);
      send_at(32'd800, CMD_POLL, 3'b000, 1'b0);
      send_at(32'd900, CMD_POLL, 3'b000, 1'b0);
      send_at(32'd1000, CMD_POLL, 3'b010, 1'b0);
      send_at(32'd1100, CMD_POLL, 3'b010, 1'b0);
      send_at(32'd1200, CMD_POLL, 3'b010, 1'b0);
      send_at(32'd1300, CMD_POLL, 3'b111, 1'b0);
      send_at(32'd1400, CMD_POLL, 3'b111, 1'b0);
      send_at(32'd1500, CMD_POLL, 3'b111, 1'b0);
      send_at(32'hFFFF_FFF0, CMD_POLL, 3'b000, 1'b1);
      send_at(32'h0000_0010, CMD_POLL, 3'b000, 1'b0);
      send_at(32'hFFFF_FFFF, CMD_CAPTURE, 3'b100, 1'b1);
      send_at(32'h0000_2000, CMD_POLL, 3'b100, 1'b0);

      run_phase(16'd50, 32'd30000, 120);
      run_phase(16'd0, 32'd0, 120);
      run_phase(16'hFFFF, 32'hFFFF_FFFF, 120);
      run_phase(16'd1, 32'h7FFF_FFFF, 120);
      run_phase(16'($urandom_range(1, 200)), 32'h8000_0000, 120);
      run_phase(16'($urandom_range(0, 65535)), $urandom(), 110);

      // hold off the receiver while items keep coming, so the input stalls
      drain();
      write_regs(16'd10, 32'd1);
      steady_send = 1'b1;
      hold_request = 1'b1;
      repeat (40) noise_item();
      steady_send = 1'b0;
      random_items(80);

      drain();
      if (failures == 0) begin
         $display("PASS switch_debounce_event_queue_unit");
      end else begin
         $display("FAIL switch_debounce_event_queue_unit");
      end
      $finish;
   end

endmodule
